// File: src/fde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_pkg
// Shared constants, types and helpers of the feedback delay echo.
// ----------------------------------------------------------------------------
package fde_pkg;

	localparam int LINE_DEPTH  = 65536;
	localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
	localparam int LEN_BITS    = ADDR_BITS + 1;
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_BITS   = 16;
	localparam int GAIN_FRAC   = 15;
	localparam int UNITY_GAIN  = 32768;
	localparam int SUM_BITS    = 20;
	localparam int PADDR_BITS  = 4;
	localparam int PDATA_BITS  = 32;
	localparam int SMP_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int SMP_MIN     = -(2 ** (SAMPLE_BITS - 1));

	// register indexes, word address divided by four
	typedef enum logic [1:0] {
		REG_LINE_LENGTH = 2'd0,
		REG_FEEDBACK    = 2'd1,
		REG_WET_MIX     = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                        line_clear;
		logic [LEN_BITS-1:0]         line_length;
		logic signed [GAIN_BITS-1:0] feedback_gain;
		logic [GAIN_BITS-1:0]        wet_mix;
	} cfg_t;

	// clamp a widened sum to the sample range
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		hi = SUM_BITS'(SMP_MAX);
		lo = SUM_BITS'(SMP_MIN);
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// File: src/fde_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_cfg_regs
// APB-style register bank: line length, feedback gain and wet mix.
// ----------------------------------------------------------------------------
module fde_cfg_regs import fde_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic      [PDATA_BITS-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic                        wr;
	reg_idx_t                    idx;
	logic [LEN_BITS-1:0]         len_q;
	logic signed [GAIN_BITS-1:0] fb_q;
	logic [GAIN_BITS-1:0]        wet_q;
	logic [LEN_BITS-1:0]         len_in;
	logic [GAIN_BITS-1:0]        wet_in;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	// clamp incoming length and wet fraction
	always_comb begin
		len_in = pwdata[LEN_BITS-1:0];
		if (len_in > LEN_BITS'(LINE_DEPTH)) begin
			len_in = LEN_BITS'(LINE_DEPTH);
		end
		wet_in = pwdata[GAIN_BITS-1:0];
		if (wet_in > GAIN_BITS'(UNITY_GAIN)) begin
			wet_in = GAIN_BITS'(UNITY_GAIN);
		end
	end

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			fb_q  <= '0;
			wet_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_LINE_LENGTH: len_q <= len_in;
				REG_FEEDBACK:    fb_q  <= pwdata[GAIN_BITS-1:0];
				REG_WET_MIX:     wet_q <= wet_in;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_LINE_LENGTH: prdata = PDATA_BITS'(len_q);
			REG_FEEDBACK:    prdata = PDATA_BITS'(unsigned'(fb_q));
			REG_WET_MIX:     prdata = PDATA_BITS'(wet_q);
			default:         prdata = '0;
		endcase
	end

	// a length write also restarts the line
	assign cfg.line_clear    = wr && (idx == REG_LINE_LENGTH);
	assign cfg.line_length   = len_q;
	assign cfg.feedback_gain = fb_q;
	assign cfg.wet_mix       = wet_q;

endmodule
`default_nettype wire

// File: src/fde_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_line_ram
// Delay line store: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module fde_line_ram import fde_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [ADDR_BITS-1:0]          waddr,
	input  wire logic signed [SAMPLE_BITS-1:0] wdata,
	input  wire logic                          re,
	input  wire logic [ADDR_BITS-1:0]          raddr,
	output logic signed [SAMPLE_BITS-1:0]      rdata
);

	logic signed [SAMPLE_BITS-1:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/fde_echo_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_echo_pipe
// Cursor, read forwarding, feedback and mix arithmetic, output register.
// ----------------------------------------------------------------------------
module fde_echo_pipe import fde_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cfg_t                          cfg,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic                               ram_we,
	output logic [ADDR_BITS-1:0]               ram_waddr,
	output logic signed [SAMPLE_BITS-1:0]      ram_wdata,
	output logic                               ram_re,
	output logic [ADDR_BITS-1:0]               ram_raddr,
	input  wire logic signed [SAMPLE_BITS-1:0] ram_rdata
);

	logic en;
	logic accept;
	logic bypass;

	logic [ADDR_BITS-1:0] cursor_q;
	logic                 wrapped_q;
	logic                 last_wrap;

	logic                          v_s1, byp_s1, rdok_s1;
	logic [ADDR_BITS-1:0]          pos_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;

	logic                          v_s2, byp_s2;
	logic [ADDR_BITS-1:0]          pos_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2, fbv_s2;
	logic signed [SUM_BITS-1:0]    dry_s2, wet_s2;

	logic                          lw_valid_q;
	logic [ADDR_BITS-1:0]          lw_pos_q;
	logic signed [SAMPLE_BITS-1:0] lw_data_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	logic signed [SAMPLE_BITS-1:0]           d;
	logic [GAIN_BITS-1:0]                    dry_gain;
	logic signed [2*SAMPLE_BITS-1:0]         fb_prod;
	logic signed [SAMPLE_BITS+GAIN_BITS:0]   dry_prod;
	logic signed [SAMPLE_BITS+GAIN_BITS:0]   wet_prod;
	logic signed [SUM_BITS-1:0]              fb_sum;
	logic signed [SUM_BITS-1:0]              mix_sum;

	// advance the whole pipe whenever the output word can move on
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;
	assign bypass   = (cfg.line_length == '0);

	// advance the cursor and note the first wrap since the line was cleared
	assign last_wrap = ({1'b0, cursor_q} + LEN_BITS'(1)) >= cfg.line_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			wrapped_q <= 1'b0;
		end else if (cfg.line_clear) begin
			cursor_q  <= '0;
			wrapped_q <= 1'b0;
		end else if (accept && !bypass) begin
			if (last_wrap) begin
				cursor_q  <= '0;
				wrapped_q <= 1'b1;
			end else begin
				cursor_q <= cursor_q + ADDR_BITS'(1);
			end
		end
	end

	// issue the line read on acceptance
	assign ram_re    = accept;
	assign ram_raddr = cursor_q;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byp_s1  <= bypass;
			rdok_s1 <= wrapped_q;
			pos_s1  <= cursor_q;
			x_s1    <= in_sample;
		end
	end

	// newest entry value: in flight, written last, stored, or zero before a wrap
	always_comb begin
		if (v_s2 && !byp_s2 && (pos_s2 == pos_s1)) begin
			d = fbv_s2;
		end else if (lw_valid_q && (lw_pos_q == pos_s1)) begin
			d = lw_data_q;
		end else if (rdok_s1) begin
			d = ram_rdata;
		end else begin
			d = '0;
		end
	end

	// feedback value and the two mix products
	always_comb begin
		dry_gain = GAIN_BITS'(UNITY_GAIN) - cfg.wet_mix;
		fb_prod  = d * cfg.feedback_gain;
		dry_prod = x_s1 * $signed({1'b0, dry_gain});
		wet_prod = d * $signed({1'b0, cfg.wet_mix});
		fb_sum   = SUM_BITS'(x_s1) + SUM_BITS'(fb_prod >>> GAIN_FRAC);
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			byp_s2 <= byp_s1;
			pos_s2 <= pos_s1;
			x_s2   <= x_s1;
			fbv_s2 <= sat_sample(fb_sum);
			dry_s2 <= SUM_BITS'(dry_prod >>> GAIN_FRAC);
			wet_s2 <= SUM_BITS'(wet_prod >>> GAIN_FRAC);
		end
	end

	// write back as the word leaves stage 2
	assign ram_we    = en && v_s2 && !byp_s2;
	assign ram_waddr = pos_s2;
	assign ram_wdata = fbv_s2;

	// keep the last write for reads that were issued alongside it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (cfg.line_clear) begin
			lw_valid_q <= 1'b0;
		end else if (ram_we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			lw_pos_q  <= pos_s2;
			lw_data_q <= fbv_s2;
		end
	end

	// output register
	assign mix_sum = dry_s2 + wet_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			out_sample_q <= byp_s2 ? x_s2 : sat_sample(mix_sum);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule
`default_nettype wire

// File: src/feedback_delay_echo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_delay_echo
// Feedback delay echo on a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready/in_sample takes one sample word per
//    cycle while in_ready is high; output channel out_valid/out_ready/
//    out_sample returns one mixed word for each input word, in order.
//  - Path: an accepted word passes stage 1 (line read on acceptance),
//    stage 2 (arithmetic) and the output register to reach out_sample.
//  - Throughput: one word per cycle while out_ready holds. The delay line
//    is a single 64K x 16 memory, read on acceptance, written as a word
//    leaves stage 2; reads that hit an entry still in flight are forwarded.
//  - Configuration over the APB-style port: line_length at 0x0, feedback_gain
//    at 0x4, wet_mix at 0x8. Write only while the block is idle. Writing
//    line_length empties the line and restarts the cursor at once; no
//    clearing pass is needed. A line_length of zero passes words through.
//  - Reset (arst_n low) empties the pipe, the line and all registers.
//  - When out_ready is low with a word waiting, the pipe holds and in_ready
//    drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module feedback_delay_echo import fde_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [PADDR_BITS-1:0]         paddr,
	input  wire logic [PDATA_BITS-1:0]         pwdata,
	output logic      [PDATA_BITS-1:0]         prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample
);

	cfg_t                          cfg;
	logic                          ram_we;
	logic [ADDR_BITS-1:0]          ram_waddr;
	logic signed [SAMPLE_BITS-1:0] ram_wdata;
	logic                          ram_re;
	logic [ADDR_BITS-1:0]          ram_raddr;
	logic signed [SAMPLE_BITS-1:0] ram_rdata;

	fde_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fde_line_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fde_echo_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

endmodule
`default_nettype wire
